### rtl/lfo_pkg.sv
// Shared constants, types and the quarter-wave sine table of the LFO block.
`timescale 1ns / 1ps
package lfo_pkg;

  localparam int PHASE_W      = 32;
  localparam int STEP_ENTRIES = 64;
  localparam int NODE_ENTRIES = 32;
  localparam int SINE_ENTRIES = 256;
  localparam int STEP_AW      = $clog2(STEP_ENTRIES);
  localparam int NODE_AW      = $clog2(NODE_ENTRIES);
  localparam int SINE_LOG     = $clog2(SINE_ENTRIES);
  localparam int SINE_FW      = 30 - SINE_LOG;
  localparam int DIV_W        = 49;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int CFG_W        = 32;

  localparam logic [30:0]         FADE_MAX    = 31'd2104533975;
  localparam logic [PHASE_W-1:0]  LFSR_MASK   = 32'h8020_0003;
  localparam logic [15:0]         NARROW_SPAN = 16'd6;

  typedef enum logic [2:0] {
    SHAPE_SINE   = 3'd0,
    SHAPE_SQUARE = 3'd1,
    SHAPE_SAW_UP = 3'd2,
    SHAPE_SAW_DN = 3'd3,
    SHAPE_TRI    = 3'd4,
    SHAPE_HOLD   = 3'd5,
    SHAPE_CUSTOM = 3'd6
  } shape_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_STEP = 2'd1,
    OP_NODE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_SHAPE      = 3'd0,
    CFG_INC        = 3'd1,
    CFG_FADE       = 3'd2,
    CFG_STEP_MODE  = 3'd3,
    CFG_STEP_COUNT = 3'd4,
    CFG_NODE_COUNT = 3'd5,
    CFG_SEED       = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_STEP_RD,
    ST_NODE_FIRST,
    ST_NODE_LAST,
    ST_NODE_SCAN,
    ST_INTERP_MUL,
    ST_FADE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] numer;
    logic [31:0]             denom;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef logic [15:0] sine_tab_t [0:SINE_ENTRIES];

  // sin(pi/2 * x) in Q30 by a fixed-point Taylor polynomial.
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] r;
    x2 = (x * x) >> 30;
    r  = 64'd172272;
    r  = 64'd5026995    - ((r * x2) >> 30);
    r  = 64'd85569306   - ((r * x2) >> 30);
    r  = 64'd693598669  - ((r * x2) >> 30);
    r  = 64'd1686629713 - ((r * x2) >> 30);
    return (r * x) >> 30;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   t;
    logic [63:0] s;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      s = (quarter_sine_q30(64'(k) << (30 - SINE_LOG)) + 64'd16384) >> 15;
      t[k] = (s > 64'd32767) ? 16'd32767 : s[15:0];
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end else if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

### rtl/lfo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lfo_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [0:Depth-1];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/lfo_div.sv
// Radix-2 restoring divider, signed numerator over unsigned divisor, truncating.
`timescale 1ns / 1ps
module lfo_div import lfo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     num_q, num_d;
  logic [31:0]          rem_q, rem_d;
  logic [31:0]          den_q, den_d;
  logic [32:0]          rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, num_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.numer[DIV_W-1];
      num_d  = req_i.numer[DIV_W-1] ? DIV_W'(-req_i.numer) : req_i.numer;
      rem_d  = '0;
      den_d  = req_i.denom;
      cnt_d  = DIV_CNT_W'(DIV_W);
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      num_d = {num_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(num_q) : $signed(num_q);
endmodule

### rtl/lfo_waveform_generator_unit.sv
// Top level of the LFO: registers, phase and random state, sequencer, tables.
//
// Input channel (in_valid_i/in_ready_o) takes one request per item: a tick,
// a step table write or a node table write. Only a tick gives a result, on
// the output channel (out_valid_o/out_ready_i): the faded level and a wrap
// flag. Table writes complete in the cycle they are accepted.
// A tick for the fixed shapes runs ST_SHAPE, ST_FADE and ST_FINISH; a node
// search adds ST_NODE_FIRST, ST_NODE_LAST and ST_NODE_SCAN (one node read per
// cycle from the node RAM). Each division (segment interpolation, edge fade)
// runs on the shared bit-serial divider; a node-interpolated tick with fade is
// the worst case. Only one tick is in flight at a time.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the following tick in its last
// step until the output register frees up.
// Reset clears the phase, the held random level and the registers to their
// defaults and loads the random generator with 1. Table contents are not
// cleared and must be written before they are used. Configuration is written
// via cfg_we_i/cfg_index_i/cfg_data_i, by the user only while idle (unchecked).
`timescale 1ns / 1ps
module lfo_waveform_generator_unit import lfo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [5:0]         entry_index_i,
  input  logic [15:0]        entry_x_i,
  input  logic signed [15:0] entry_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] lfo_value_o,
  output logic               cycle_wrapped_o
);
  state_e state_q, state_d;

  shape_e               shape_q;
  logic [31:0]          inc_q;
  logic [30:0]          fade_q;
  logic                 step_mode_q;
  logic [6:0]           step_count_q;
  logic [5:0]           node_count_q;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [PHASE_W-1:0]   lfsr_q, lfsr_d;
  logic signed [15:0]   held_q, held_d;
  logic                 wrapped_q, wrapped_d;

  logic signed [15:0]   value_q, value_d;
  logic [15:0]          prev_x_q, prev_x_d;
  logic signed [15:0]   prev_y_q, prev_y_d;
  logic [15:0]          cur_x_q, cur_x_d;
  logic signed [15:0]   cur_y_q, cur_y_d;
  logic [NODE_AW-1:0]   scan_q, scan_d;
  logic signed [DIV_W-1:0] numer_q, numer_d;
  logic [31:0]          denom_q, denom_d;
  logic                 div_fade_q, div_fade_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [15:0]   lfo_value_q;
  logic                 cycle_wrapped_q;
  logic                 out_load;

  logic accept;
  logic cfg_seed_we;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_seed_we = cfg_we_i && (cfg_index_i == CFG_SEED);

  // Tables
  logic               step_we;
  logic [STEP_AW-1:0] step_raddr;
  logic [15:0]        step_rdata;
  logic               node_we;
  logic [NODE_AW-1:0] node_raddr;
  logic [31:0]        node_rdata;

  assign step_we = accept && (operation_i == OP_STEP) && (32'(entry_index_i) < STEP_ENTRIES);
  assign node_we = accept && (operation_i == OP_NODE) && (32'(entry_index_i) < NODE_ENTRIES);

  lfo_ram #(.Width(16), .Depth(STEP_ENTRIES)) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (step_we),
    .waddr_i (entry_index_i[STEP_AW-1:0]),
    .wdata_i (entry_y_i),
    .raddr_i (step_raddr),
    .rdata_o (step_rdata)
  );

  lfo_ram #(.Width(32), .Depth(NODE_ENTRIES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (entry_index_i[NODE_AW-1:0]),
    .wdata_i ({entry_x_i, entry_y_i}),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // Divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start = (state_q == ST_DIV_GO);
  assign div_req.numer = numer_q;
  assign div_req.denom = denom_q;

  lfo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Phase step and random generator
  logic [PHASE_W:0]   phase_sum;
  logic [PHASE_W-1:0] lfsr_next;

  assign phase_sum = {1'b0, phase_q} + {1'b0, inc_q};

  always_comb begin
    lfsr_next = lfsr_q >> 1;
    if (lfsr_q[0]) begin
      lfsr_next = lfsr_next ^ LFSR_MASK;
    end
    if (lfsr_next == '0) begin
      lfsr_next = PHASE_W'(1);
    end
  end

  // Fixed shapes at the current phase
  logic [15:0]        u;
  logic [30:0]        sine_f;
  logic [SINE_LOG:0]  sine_k;
  logic [SINE_FW-1:0] sine_fr;
  logic [15:0]        sine_a, sine_b, sine_d, sine_v;
  logic [SINE_FW+15:0] sine_prod;
  logic signed [15:0] shape_v;

  assign u       = phase_q[31:16];
  assign sine_f  = phase_q[30] ? (31'h4000_0000 - {1'b0, phase_q[29:0]})
                               : {1'b0, phase_q[29:0]};
  assign sine_k  = sine_f[30:30-SINE_LOG];
  assign sine_fr = sine_f[SINE_FW-1:0];
  assign sine_a  = SINE_TAB[sine_k];
  assign sine_b  = sine_k[SINE_LOG] ? sine_a : SINE_TAB[sine_k + 1'b1];
  assign sine_d  = ($signed(sine_b) > $signed(sine_a)) ? 16'(sine_b - sine_a) : 16'd0;
  assign sine_prod = sine_d * sine_fr;
  assign sine_v  = sine_k[SINE_LOG] ? SINE_TAB[SINE_ENTRIES]
                                    : 16'(sine_a + sine_prod[SINE_FW+15:SINE_FW]);

  always_comb begin
    case (shape_q)
      SHAPE_SINE:   shape_v = phase_q[31] ? -$signed(sine_v) : $signed(sine_v);
      SHAPE_SQUARE: shape_v = phase_q[31] ? 16'sh8000 : 16'sh7fff;
      SHAPE_SAW_UP: shape_v = {~u[15], u[14:0]};
      SHAPE_SAW_DN: shape_v = sat16(20'sd32768 - $signed({4'b0, u}));
      SHAPE_TRI: begin
        if (!u[15]) begin
          shape_v = sat16($signed({3'b0, u, 1'b0}) - 20'sd32768);
        end else begin
          shape_v = sat16(20'sd98304 - $signed({3'b0, u, 1'b0}));
        end
      end
      SHAPE_HOLD:   shape_v = held_q;
      default:      shape_v = 16'sd0;
    endcase
  end

  // Custom step index
  logic [6:0]  step_n;
  logic [38:0] step_prod;
  logic [6:0]  step_idx;

  assign step_n    = (step_count_q > 7'(STEP_ENTRIES)) ? 7'(STEP_ENTRIES) : step_count_q;
  assign step_prod = phase_q * step_n;
  always_comb begin
    step_idx = step_prod[38:32];
    if (step_n == '0) begin
      step_idx = '0;
    end else if (step_idx > step_n - 1'b1) begin
      step_idx = step_n - 1'b1;
    end
  end
  assign step_raddr = step_idx[STEP_AW-1:0];

  // Node search
  logic [5:0]         node_n;
  logic [15:0]        rd_x;
  logic signed [15:0] rd_y;
  logic               le_rd, ge_rd, ge_prev, seg_hit, narrow, scan_last;

  assign node_n    = (node_count_q > 6'(NODE_ENTRIES)) ? 6'(NODE_ENTRIES) : node_count_q;
  assign rd_x      = node_rdata[31:16];
  assign rd_y      = node_rdata[15:0];
  assign le_rd     = (u < rd_x) || ((u == rd_x) && (phase_q[15:0] == '0));
  assign ge_rd     = (u >= rd_x);
  assign ge_prev   = (u >= prev_x_q);
  assign seg_hit   = ge_prev && le_rd;
  assign narrow    = 16'(rd_x - prev_x_q) <= NARROW_SPAN;
  assign scan_last = ({1'b0, scan_q} == node_n - 1'b1);

  always_comb begin
    case (state_q)
      ST_SHAPE:      node_raddr = '0;
      ST_NODE_FIRST: node_raddr = NODE_AW'(node_n - 1'b1);
      ST_NODE_LAST:  node_raddr = NODE_AW'(1);
      ST_NODE_SCAN:  node_raddr = scan_q + 1'b1;
      default:       node_raddr = '0;
    endcase
  end

  // Edge fade
  logic        fade_on, fade_lo, fade_hi;
  logic [30:0] fade_w;
  logic [31:0] fade_m;

  assign fade_on = (fade_q != '0) && (inc_q != '0);
  assign fade_w  = (fade_q > FADE_MAX) ? FADE_MAX : fade_q;
  assign fade_lo = phase_q < {1'b0, fade_w};
  assign fade_hi = ({1'b0, phase_q} + {2'b0, fade_w}) > 33'h1_0000_0000;
  assign fade_m  = fade_lo ? phase_q : 32'(32'd0 - phase_q);

  // Output register
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_TICK)) begin
          state_d = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        if (shape_q != SHAPE_CUSTOM) begin
          state_d = ST_FADE;
        end else if (step_mode_q) begin
          state_d = ST_STEP_RD;
        end else if (node_n == '0) begin
          state_d = ST_FADE;
        end else begin
          state_d = ST_NODE_FIRST;
        end
      end
      ST_STEP_RD:    state_d = ST_FADE;
      ST_NODE_FIRST: state_d = le_rd ? ST_FADE : ST_NODE_LAST;
      ST_NODE_LAST:  state_d = ge_rd ? ST_FADE : ST_NODE_SCAN;
      ST_NODE_SCAN: begin
        if (seg_hit) begin
          state_d = narrow ? ST_FADE : ST_INTERP_MUL;
        end else if (scan_last) begin
          state_d = ST_FADE;
        end
      end
      ST_INTERP_MUL: state_d = ST_DIV_GO;
      ST_FADE:       state_d = (fade_on && (fade_lo || fade_hi)) ? ST_DIV_GO : ST_FINISH;
      ST_DIV_GO:     state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = div_fade_q ? ST_FINISH : ST_FADE;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    phase_d    = phase_q;
    lfsr_d     = lfsr_q;
    held_d     = held_q;
    wrapped_d  = wrapped_q;
    value_d    = value_q;
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    scan_d     = scan_q;
    numer_d    = numer_q;
    denom_d    = denom_q;
    div_fade_d = div_fade_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_TICK)) begin
          phase_d   = phase_sum[PHASE_W-1:0];
          wrapped_d = phase_sum[PHASE_W];
          if (phase_sum[PHASE_W]) begin
            lfsr_d = lfsr_next;
            held_d = lfsr_next[31:16];
          end
        end
      end
      ST_SHAPE: value_d = (shape_q == SHAPE_CUSTOM) ? 16'sd0 : shape_v;
      ST_STEP_RD: value_d = step_rdata;
      ST_NODE_FIRST: begin
        value_d  = rd_y;
        prev_x_d = rd_x;
        prev_y_d = rd_y;
      end
      ST_NODE_LAST: begin
        value_d = ge_rd ? rd_y : 16'sd0;
        scan_d  = NODE_AW'(1);
      end
      ST_NODE_SCAN: begin
        if (seg_hit) begin
          value_d = prev_y_q;
          cur_x_d = rd_x;
          cur_y_d = rd_y;
        end else begin
          value_d  = 16'sd0;
          prev_x_d = rd_x;
          prev_y_d = rd_y;
          scan_d   = scan_q + 1'b1;
        end
      end
      ST_INTERP_MUL: begin
        numer_d = DIV_W'((20'(cur_y_q) - 20'(prev_y_q))
                         * $signed({1'b0, 32'(phase_q - {prev_x_q, 16'h0})}));
        denom_d    = {16'(cur_x_q - prev_x_q), 16'h0};
        div_fade_d = 1'b0;
      end
      ST_FADE: begin
        numer_d    = value_q * $signed({1'b0, fade_m});
        denom_d    = {1'b0, fade_w};
        div_fade_d = 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (div_fade_q) begin
            value_d = div_rsp.quot[15:0];
          end else begin
            value_d = sat16(20'(prev_y_q) + 20'($signed(div_rsp.quot[17:0])));
          end
        end
      end
      default: ;
    endcase
    // The seed write restarts the random sequence.
    if (cfg_seed_we) begin
      lfsr_d = (cfg_data_i == '0) ? PHASE_W'(1) : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      shape_q      <= SHAPE_SINE;
      inc_q        <= '0;
      fade_q       <= '0;
      step_mode_q  <= 1'b0;
      step_count_q <= 7'd16;
      node_count_q <= '0;
      phase_q      <= '0;
      lfsr_q       <= PHASE_W'(1);
      held_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lfsr_q      <= lfsr_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SHAPE:      shape_q      <= shape_e'(cfg_data_i[2:0]);
          CFG_INC:        inc_q        <= cfg_data_i;
          CFG_FADE:       fade_q       <= cfg_data_i[30:0];
          CFG_STEP_MODE:  step_mode_q  <= cfg_data_i[0];
          CFG_STEP_COUNT: step_count_q <= cfg_data_i[6:0];
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wrapped_q  <= wrapped_d;
    value_q    <= value_d;
    prev_x_q   <= prev_x_d;
    prev_y_q   <= prev_y_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    scan_q     <= scan_d;
    numer_q    <= numer_d;
    denom_q    <= denom_d;
    div_fade_q <= div_fade_d;
    if (out_load) begin
      lfo_value_q     <= value_q;
      cycle_wrapped_q <= wrapped_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lfo_value_o     = lfo_value_q;
  assign cycle_wrapped_o = cycle_wrapped_q;
endmodule

### dv/lfo_waveform_generator_unit_tb.sv
// Testbench of the LFO waveform generator: random requests checked against a built-in predictor.
`timescale 1ns / 1ps
module lfo_waveform_generator_unit_tb;
  import lfo_pkg::*;

  typedef struct {
    logic signed [15:0] level;
    logic               wrap;
  } lfo_result_t;

  class lfo_scoreboard;
    logic [2:0]         shape;
    logic [31:0]        inc;
    logic [30:0]        fade;
    logic               step_mode;
    logic [6:0]         step_count;
    logic [5:0]         node_count;
    logic [31:0]        phase;
    logic signed [15:0] held;
    logic [31:0]        lfsr;
    logic signed [15:0] step_tab [STEP_ENTRIES];
    logic [15:0]        node_x [NODE_ENTRIES];
    logic signed [15:0] node_y [NODE_ENTRIES];
    int                 sine_tab [SINE_ENTRIES + 1];
    lfo_result_t        levels_due [$];
    int                 errors;

    function new();
      longint unsigned x, s;
      shape = SHAPE_SINE;
      inc = 0;
      fade = 0;
      step_mode = 0;
      step_count = 16;
      node_count = 0;
      phase = 0;
      held = 0;
      lfsr = 1;
      errors = 0;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
        x = (longint'(k) << 30) / SINE_ENTRIES;
        s = (quarter_wave(x) + 64'd16384) >> 15;
        sine_tab[k] = (s > 32767) ? 32767 : int'(s);
      end
    endfunction

    // Taylor series for sin(pi/2 * x), argument and result in Q30.
    function longint unsigned quarter_wave(longint unsigned x);
      longint unsigned x2, r;
      x2 = (x * x) >> 30;
      r = 172272;
      r = 5026995 - ((r * x2) >> 30);
      r = 85569306 - ((r * x2) >> 30);
      r = 693598669 - ((r * x2) >> 30);
      r = 1686629713 - ((r * x2) >> 30);
      return (r * x) >> 30;
    endfunction

    function int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int sine_level(logic [31:0] p);
      longint unsigned f, pos, k, fr, d;
      int a, b, v;
      f = p[29:0];
      if (p[30]) f = (64'd1 << 30) - f;
      pos = f * SINE_ENTRIES;
      k = pos >> 30;
      fr = pos & ((64'd1 << 30) - 1);
      if (k >= SINE_ENTRIES) begin
        v = sine_tab[SINE_ENTRIES];
      end else begin
        a = sine_tab[k];
        b = sine_tab[k + 1];
        d = (b > a) ? longint'(b - a) : 0;
        v = a + int'((d * fr) >> 30);
      end
      return p[31] ? -v : v;
    endfunction

    function int custom_level(logic [31:0] p);
      longint unsigned cnt, idx, x0, x1;
      longint dy, off;
      int n;
      if (step_mode) begin
        cnt = (step_count > STEP_ENTRIES) ? STEP_ENTRIES : step_count;
        if (cnt == 0) return step_tab[0];
        idx = (longint'(p) * cnt) >> 32;
        if (idx > cnt - 1) idx = cnt - 1;
        return step_tab[idx];
      end
      n = (node_count > NODE_ENTRIES) ? NODE_ENTRIES : node_count;
      if (n == 0) return 0;
      if (longint'(p) <= (longint'(node_x[0]) << 16)) return node_y[0];
      if (longint'(p) >= (longint'(node_x[n-1]) << 16)) return node_y[n-1];
      for (int i = 0; i + 1 < n; i++) begin
        x0 = longint'(node_x[i]) << 16;
        x1 = longint'(node_x[i+1]) << 16;
        if (p >= x0 && p <= x1) begin
          // Segments narrower than a ten-thousandth of a cycle hold the left level.
          if (node_x[i+1] - node_x[i] <= 16'd6) return node_y[i];
          dy = longint'(node_y[i+1]) - longint'(node_y[i]);
          off = (dy * longint'(longint'(p) - x0)) / longint'(x1 - x0);
          return clip16(longint'(node_y[i]) + off);
        end
      end
      return 0;
    endfunction

    function int shape_level(logic [31:0] p);
      int u;
      u = int'(p[31:16]);
      case (shape)
        SHAPE_SINE:   return sine_level(p);
        SHAPE_SQUARE: return p[31] ? -32768 : 32767;
        SHAPE_SAW_UP: return u - 32768;
        SHAPE_SAW_DN: return clip16(32768 - u);
        SHAPE_TRI:    return (u < 32768) ? 2 * u - 32768 : clip16(98304 - 2 * u);
        SHAPE_HOLD:   return held;
        SHAPE_CUSTOM: return custom_level(p);
        default:      return 0;
      endcase
    endfunction

    function int faded(int v, logic [31:0] p);
      longint f;
      if (fade == 0 || inc == 0) return v;
      f = (fade > FADE_MAX) ? FADE_MAX : fade;
      if (longint'(p) < f) return int'((longint'(v) * longint'(p)) / f);
      if (longint'(p) > (64'sd1 <<< 32) - f)
        return int'((longint'(v) * ((64'sd1 <<< 32) - longint'(p))) / f);
      return v;
    endfunction

    function void configure(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_SHAPE:      shape = data[2:0];
        CFG_INC:        inc = data;
        CFG_FADE:       fade = data[30:0];
        CFG_STEP_MODE:  step_mode = data[0];
        CFG_STEP_COUNT: step_count = data[6:0];
        CFG_NODE_COUNT: node_count = data[5:0];
        CFG_SEED:       lfsr = (data == 0) ? 32'd1 : data;
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] op, logic [5:0] idx, logic [15:0] x,
                               logic signed [15:0] y);
      logic [32:0] sum;
      lfo_result_t r;
      case (op)
        OP_STEP: step_tab[idx] = y;
        OP_NODE: begin
          if (idx < NODE_ENTRIES) begin
            node_x[idx] = x;
            node_y[idx] = y;
          end
        end
        OP_TICK: begin
          sum = {1'b0, phase} + {1'b0, inc};
          phase = sum[31:0];
          if (sum[32]) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
            if (lfsr == 0) lfsr = 1;
            held = lfsr[31:16];
          end
          r.level = 16'(faded(shape_level(phase), phase));
          r.wrap = sum[32];
          levels_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [15:0] level, logic wrap);
      lfo_result_t e;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected result level %0d wrap %0b", $time, level, wrap);
        errors++;
        return;
      end
      e = levels_due.pop_front();
      if (level !== e.level) begin
        $display("%0t: level expected %0d actual %0d", $time, e.level, level);
        errors++;
      end
      if (wrap !== e.wrap) begin
        $display("%0t: wrap expected %0b actual %0b", $time, e.wrap, wrap);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [2:0]         cfg_index_i = 0;
  logic [CFG_W-1:0]   cfg_data_i = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic [1:0]         operation_i = 0;
  logic [5:0]         entry_index_i = 0;
  logic [15:0]        entry_x_i = 0;
  logic signed [15:0] entry_y_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic signed [15:0] lfo_value_o;
  logic               cycle_wrapped_o;

  lfo_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;
  int node_cursor = 0;

  lfo_waveform_generator_unit dut (.*);

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(lfo_value_o, cycle_wrapped_o);
      if (in_valid_i && in_ready_o)
        sb.note_request(operation_i, entry_index_i, entry_x_i, entry_y_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 20000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [5:0] idx, logic [15:0] x,
                              logic [15:0] y);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1;
    operation_i <= op;
    entry_index_i <= idx;
    entry_x_i <= x;
    entry_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.levels_due.size() != 0) @(posedge clk_i);
    // A write leaves no result, so let any tick still in flight settle.
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    sb.configure(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Most node writes (the others are random) walk up through the table in ascending x so the search sees sorted sets.
  task automatic random_request();
    int pick;
    logic [5:0] idx;
    logic [15:0] x;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_request(OP_TICK, 6'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 82) begin
      send_request(OP_STEP, 6'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 95) begin
      if ($urandom_range(99) < 80) begin
        idx = 6'(node_cursor);
        x = 16'(node_cursor * 2048 + $urandom_range(2047));
        node_cursor = (node_cursor + 1) % NODE_ENTRIES;
      end else begin
        idx = 6'($urandom);
        x = 16'($urandom);
      end
      send_request(OP_NODE, idx, x, 16'($urandom));
    end else begin
      send_request(2'd3, 6'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [31:0] v;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Fill both tables first; entries are never read before they are written.
    for (int k = 0; k < STEP_ENTRIES; k++)
      send_request(OP_STEP, 6'(k), 16'(k), (k % 3 == 0) ? 16'h8000 :
                   (k % 3 == 1) ? 16'h7fff : 16'($urandom));
    for (int k = 0; k < NODE_ENTRIES; k++)
      send_request(OP_NODE, 6'(k), (k == 5) ? 16'(4 * 2048 + 3) : 16'(k * 2048),
                   k[0] ? 16'h7fff : 16'h8000);
    send_request(OP_NODE, 6'd40, 16'hffff, 16'h7fff);
    send_request(OP_NODE, 6'd63, 16'h0000, 16'h8000);
    send_request(2'd3, 6'h3f, 16'hffff, 16'hffff);
    repeat (3) send_request(OP_TICK, 6'h00, 16'h0000, 16'h0000);
    send_request(OP_TICK, 6'h3f, 16'hffff, 16'hffff);

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      tx_idle_pct = (ph < 5) ? 26 : (ph < 10) ? 62 : 0;
      rx_idle_pct = (ph < 5) ? 62 : (ph < 10) ? 26 : 0;
      write_cfg(CFG_SHAPE, 32'(ph % 8));
      case (ph % 4)
        0: v = 32'hffff_ffff;
        1: v = 32'h1;
        2: v = 32'($urandom_range(32'h7fff_ffff, 32'h0400_0000));
        default: v = (ph == 3) ? 32'h0 : $urandom;
      endcase
      write_cfg(CFG_INC, v);
      case (ph % 3)
        0: v = 32'h0;
        1: v = 32'h7fff_ffff;
        default: v = $urandom;
      endcase
      write_cfg(CFG_FADE, v);
      write_cfg(CFG_STEP_MODE, 32'((ph / 8) ^ (ph % 2)));
      case (ph % 5)
        0: v = 32'd0;
        1: v = 32'd1;
        2: v = 32'd64;
        3: v = 32'd127;
        default: v = $urandom_range(127);
      endcase
      write_cfg(CFG_STEP_COUNT, v);
      case (ph % 5)
        0: v = 32'd32;
        1: v = 32'd0;
        2: v = 32'd1;
        3: v = 32'd63;
        default: v = $urandom_range(63);
      endcase
      write_cfg(CFG_NODE_COUNT, v);
      case (ph % 4)
        0: v = 32'h0;
        1: v = 32'hffff_ffff;
        default: v = $urandom;
      endcase
      write_cfg(CFG_SEED, v);
      for (int n = 0; n < 125; n++) begin
        random_request();
        if (ph == 3 && n == 60) begin
          @(negedge clk_i);
          in_valid_i <= 0;
          while (sb.levels_due.size() != 0) @(posedge clk_i);
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### lfo_waveform_generator_unit.f
rtl/lfo_pkg.sv
rtl/lfo_ram.sv
rtl/lfo_div.sv
rtl/lfo_waveform_generator_unit.sv
dv/lfo_waveform_generator_unit_tb.sv
